>>> rtl/core/tts_pkg.sv
// ----------------------------------------------------------------------------
// tts_pkg
// Shared types and codes for the timed toggle pattern sequencer.
// ----------------------------------------------------------------------------
package tts_pkg;

	// Item kinds carried on the input tuser field.
	typedef enum logic [2:0] {
		KIND_TICK    = 3'd0,
		KIND_START   = 3'd1,
		KIND_STOP    = 3'd2,
		KIND_RESTART = 3'd3,
		KIND_LOAD    = 3'd4
	} kind_t;

	// Configuration register indexes.
	typedef enum logic [2:0] {
		REG_ACTIVE_STEPS   = 3'd0,
		REG_REPEAT_SETTING = 3'd1,
		REG_DRIVE_ENABLE   = 3'd2,
		REG_INITIAL_LEVEL  = 3'd3,
		REG_END_LEVEL      = 3'd4
	} reg_index_t;

	localparam int unsigned KIND_W     = 3;
	localparam int unsigned INDEX_W    = 4;
	localparam int unsigned DUR_PORT_W = 32;
	localparam int unsigned REPEAT_W   = 16;
	localparam int unsigned CFG_DATA_W = 16;

	typedef struct packed {
		logic [4:0]                 active_steps;
		logic signed [REPEAT_W-1:0] repeat_setting;
		logic                       drive_enable;
		logic                       initial_level;
		logic                       end_level;
	} cfg_t;

	typedef struct packed {
		logic                       finished;
		logic                       looped;
		logic                       toggled;
		logic signed [REPEAT_W-1:0] repeats_left;
		logic [INDEX_W-1:0]         current_step;
		logic                       is_running;
		logic                       phase_level;
		logic                       pin_level;
	} result_t;

endpackage

>>> rtl/core/tts_table.sv
// ----------------------------------------------------------------------------
// tts_table
// Step duration storage: one write port, one asynchronous read port.
// ----------------------------------------------------------------------------
module tts_table #(
	parameter int unsigned MAX_STEPS     = 16,
	parameter int unsigned DURATION_BITS = 32,
	parameter int unsigned STEP_W        = 4
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [STEP_W-1:0]        wr_addr,
	input  logic [DURATION_BITS-1:0] wr_data,
	input  logic [STEP_W-1:0]        rd_addr,
	output logic [DURATION_BITS-1:0] rd_data
);

	// Entries hold no reset value; they are defined once loaded.
	logic [DURATION_BITS-1:0] dur_q [MAX_STEPS];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			dur_q[wr_addr] <= wr_data;
		end
	end

	assign rd_data = dur_q[rd_addr];

endmodule

>>> rtl/core/tts_engine.sv
// ----------------------------------------------------------------------------
// tts_engine
// Sequencer state and the combinational update for one item.
// ----------------------------------------------------------------------------
module tts_engine #(
	parameter int unsigned MAX_STEPS     = 16,
	parameter int unsigned DURATION_BITS = 32,
	parameter int unsigned STEP_W        = 4
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              fire,
	input  logic [tts_pkg::KIND_W-1:0]        kind,
	input  logic [tts_pkg::INDEX_W-1:0]       step_index,
	input  logic [tts_pkg::DUR_PORT_W-1:0]    step_duration,
	input  tts_pkg::cfg_t                     cfg,
	output tts_pkg::result_t                  res
);

	localparam int unsigned CNT_W = $clog2(MAX_STEPS + 1);

	logic [DURATION_BITS-1:0]            elapsed_q, elapsed_n;
	logic [STEP_W-1:0]                   step_q, step_n;
	logic signed [tts_pkg::REPEAT_W-1:0] rep_q, rep_n, rep_dec;
	logic                                phase_q, phase_n;
	logic                                pin_q, pin_n;
	logic                                running_q, running_n;
	logic                                toggled, looped, finished;

	logic [CNT_W-1:0]         steps_used;
	logic [CNT_W-1:0]         step_inc;
	logic [DURATION_BITS-1:0] cur_dur;
	logic [DURATION_BITS-1:0] load_dur;
	logic                     load_en;

	always_comb begin
		if (cfg.active_steps == 5'd0) begin
			steps_used = CNT_W'(1);
		end else if (32'(cfg.active_steps) > MAX_STEPS) begin
			steps_used = CNT_W'(MAX_STEPS);
		end else begin
			steps_used = CNT_W'(cfg.active_steps);
		end
	end

	// Loaded durations are masked to the counter width; zero becomes one.
	always_comb begin
		load_dur = DURATION_BITS'(step_duration);
		if (load_dur == '0) begin
			load_dur = DURATION_BITS'(1);
		end
	end

	assign load_en = fire && (kind == tts_pkg::KIND_LOAD) && (32'(step_index) < MAX_STEPS);

	tts_table #(
		.MAX_STEPS    (MAX_STEPS),
		.DURATION_BITS(DURATION_BITS),
		.STEP_W       (STEP_W)
	) u_table (
		.clk    (clk),
		.wr_en  (load_en),
		.wr_addr(STEP_W'(step_index)),
		.wr_data(load_dur),
		.rd_addr(step_q),
		.rd_data(cur_dur)
	);

	assign step_inc = CNT_W'(step_q) + CNT_W'(1);
	assign rep_dec  = (rep_q > 16'sd0) ? rep_q - 16'sd1 : rep_q;

	always_comb begin
		elapsed_n = elapsed_q;
		step_n    = step_q;
		rep_n     = rep_q;
		phase_n   = phase_q;
		pin_n     = pin_q;
		running_n = running_q;
		toggled   = 1'b0;
		looped    = 1'b0;
		finished  = 1'b0;
		unique case (kind)
			tts_pkg::KIND_TICK: begin
				if (running_q) begin
					if (elapsed_q >= cur_dur) begin
						// Excess time carries into the next step.
						elapsed_n = elapsed_q - cur_dur + DURATION_BITS'(1);
						if (step_inc >= steps_used) begin
							step_n = '0;
							rep_n  = rep_dec;
							if (rep_dec == 16'sd0) begin
								running_n = 1'b0;
								finished  = 1'b1;
								if (cfg.drive_enable) begin
									pin_n = cfg.end_level;
								end
							end else begin
								looped = 1'b1;
							end
						end else begin
							step_n = STEP_W'(step_inc);
						end
						if (!finished) begin
							phase_n = ~phase_q;
							toggled = 1'b1;
							if (cfg.drive_enable) begin
								pin_n = ~phase_q;
							end
						end
					end else begin
						elapsed_n = elapsed_q + DURATION_BITS'(1);
					end
				end
			end
			tts_pkg::KIND_START, tts_pkg::KIND_RESTART: begin
				step_n    = '0;
				elapsed_n = '0;
				running_n = 1'b1;
				phase_n   = cfg.initial_level;
				rep_n     = cfg.repeat_setting;
				if (cfg.drive_enable) begin
					pin_n = cfg.initial_level;
				end
			end
			tts_pkg::KIND_STOP: begin
				running_n = 1'b0;
				step_n    = '0;
				rep_n     = cfg.repeat_setting;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			elapsed_q <= '0;
			step_q    <= '0;
			rep_q     <= '0;
			phase_q   <= 1'b0;
			pin_q     <= 1'b0;
			running_q <= 1'b0;
		end else if (fire) begin
			elapsed_q <= elapsed_n;
			step_q    <= step_n;
			rep_q     <= rep_n;
			phase_q   <= phase_n;
			pin_q     <= pin_n;
			running_q <= running_n;
		end
	end

	always_comb begin
		res.pin_level    = pin_n;
		res.phase_level  = phase_n;
		res.is_running   = running_n;
		res.current_step = tts_pkg::INDEX_W'(step_n);
		res.repeats_left = rep_n;
		res.toggled      = toggled;
		res.looped       = looped;
		res.finished     = finished;
	end

	a_finish_stops: assert property (@(posedge clk) disable iff (!arst_n)
		fire && finished |=> !running_q && step_q == '0)
		else $error("run did not stop after its final pass");

	a_toggle_excl: assert property (@(posedge clk) disable iff (!arst_n)
		fire |-> !(toggled && finished) && !(looped && finished))
		else $error("final wrap reported a toggle or a loop");

	a_idle_tick: assert property (@(posedge clk) disable iff (!arst_n)
		fire && !running_q && kind == tts_pkg::KIND_TICK |=> $stable(elapsed_q) && !running_q)
		else $error("tick changed state while stopped");

endmodule

>>> rtl/core/timed_toggle_pattern_sequencer.sv
// ----------------------------------------------------------------------------
// timed_toggle_pattern_sequencer
// Programmable pulse pattern generator driven by millisecond tick items.
// ----------------------------------------------------------------------------
// Usage: items enter on the s_axis channel. tuser holds the kind (tick,
// start, stop, restart, load step); tdata holds the step index and, for a
// load, the step duration. Every accepted item yields exactly one result on
// the m_axis channel, reporting pin and phase levels, run state, the current
// step, the remaining repeat count and the toggled, looped and finished flags.
// Configuration registers are written over the cfg channel, which is always
// ready; write them only while no item is in flight.
// Pipeline: an accepted item is held in the input register, and its result is
// captured in the result register when the engine fires. One item is accepted
// every cycle while the receiver keeps taking results; the state update, one table
// read, one compare and one subtract all fit between the input register and the result register.
// Reset clears the run state and restores register defaults; the duration
// table is not cleared and must be loaded before it is used. When the
// receiver stalls, the result register holds and the input register fills,
// after which s_axis_tready drops until the result is taken.
// ----------------------------------------------------------------------------
module timed_toggle_pattern_sequencer #(
	parameter int unsigned MAX_STEPS     = 16,
	parameter int unsigned DURATION_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	// Input items
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,  // step_index[3:0], step_duration[35:4], zero pad
	input  logic [2:0]  s_axis_tuser,  // kind[2:0]
	// Result items
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,  // pin_level[0], phase_level[1], is_running[2],
	                                   // current_step[6:3], repeats_left[22:7],
	                                   // toggled[23], looped[24], finished[25], zero pad
	// Configuration writes
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	localparam int unsigned STEP_W = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;

	logic                                  s1_valid_q;
	logic [tts_pkg::KIND_W-1:0]            kind_s1;
	logic [tts_pkg::INDEX_W-1:0]           index_s1;
	logic [tts_pkg::DUR_PORT_W-1:0]        dur_s1;
	logic                                  out_valid_q;
	tts_pkg::result_t                      out_q;
	tts_pkg::result_t                      res;
	tts_pkg::cfg_t                         cfg_q;
	logic                                  advance;
	logic                                  fire;

	// The input register moves on whenever the result register is free or drains.
	assign advance       = !out_valid_q || m_axis_tready;
	assign fire          = s1_valid_q && advance;
	assign s_axis_tready = !s1_valid_q || advance;
	assign cfg_ready     = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (s_axis_tready) begin
			s1_valid_q <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			kind_s1  <= s_axis_tuser;
			index_s1 <= s_axis_tdata[3:0];
			dur_s1   <= s_axis_tdata[35:4];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.active_steps   <= 5'd1;
			cfg_q.repeat_setting <= 16'sd0;
			cfg_q.drive_enable   <= 1'b0;
			cfg_q.initial_level  <= 1'b1;
			cfg_q.end_level      <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				tts_pkg::REG_ACTIVE_STEPS:   cfg_q.active_steps   <= cfg_data[4:0];
				tts_pkg::REG_REPEAT_SETTING: cfg_q.repeat_setting <= cfg_data;
				tts_pkg::REG_DRIVE_ENABLE:   cfg_q.drive_enable   <= cfg_data[0];
				tts_pkg::REG_INITIAL_LEVEL:  cfg_q.initial_level  <= cfg_data[0];
				tts_pkg::REG_END_LEVEL:      cfg_q.end_level      <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	tts_engine #(
		.MAX_STEPS    (MAX_STEPS),
		.DURATION_BITS(DURATION_BITS),
		.STEP_W       (STEP_W)
	) u_engine (
		.clk          (clk),
		.arst_n       (arst_n),
		.fire         (fire),
		.kind         (kind_s1),
		.step_index   (index_s1),
		.step_duration(dur_s1),
		.cfg          (cfg_q),
		.res          (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= s1_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {6'd0, out_q.finished, out_q.looped, out_q.toggled,
		out_q.repeats_left, out_q.current_step, out_q.is_running,
		out_q.phase_level, out_q.pin_level};

	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q && !advance |=> s1_valid_q && $stable(kind_s1) && $stable(dur_s1))
		else $error("input register lost an item during a stall");

	a_fire_delivers: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> out_valid_q)
		else $error("processed item did not reach the result register");

	a_no_accept_full: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q && out_valid_q && !m_axis_tready |-> !s_axis_tready)
		else $error("item accepted while both registers are full");

endmodule
